// ===== src/qpht_pkg.sv =====
// Shared types, constants and helpers of the quadratic probe hash table.
package qpht_pkg;

    localparam int DEPTH  = 64;
    localparam int NW     = $clog2(DEPTH + 1);
    localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KEY_W  = 31;
    localparam int CMD_W  = 2;
    localparam int SLOT_W = 6;
    localparam int TS_W   = 7;
    localparam int ST_W   = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
    localparam logic [ST_W-1:0] ST_USED  = 2'd1;
    localparam logic [ST_W-1:0] ST_GONE  = 2'd2;

    localparam logic [TS_W-1:0] TS_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic          done;
        logic [NW-1:0] rem;
    } t_mod_res;

    // Clamp the programmed table size into 1..DEPTH.
    function automatic logic [NW-1:0] eff_size(input logic [TS_W-1:0] ts);
        logic [NW-1:0] n;
        if (ts == '0) begin
            n = NW'(1);
        end else if (32'(ts) > DEPTH) begin
            n = NW'(DEPTH);
        end else begin
            n = NW'(ts);
        end
        return n;
    endfunction

endpackage

// ===== src/qpht_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface qpht_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [qpht_pkg::CMD_W-1:0]  command;
    logic [qpht_pkg::KEY_W-1:0]  key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface qpht_res_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [qpht_pkg::SLOT_W-1:0] slot_index;

    modport source (output valid, output hit, output slot_index, input ready);
    modport sink   (input valid, input hit, input slot_index, output ready);
endinterface

// ===== src/quadratic_probe_hash_table.sv =====
// Top level of the open-addressing hash table with quadratic probing.
// A command's key is first reduced bit-serially modulo the table size, then slots are probed,
// one slot per cycle; p (1 to the effective table size) is the number of slots probed.
// The unused command skips both steps and goes straight to its result.
// One command is in flight at a time: the next is taken only after this result is registered.
// Synchronous active-low reset: table_size goes to 64, all slots read empty via valid flops.
module quadratic_probe_hash_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qpht_cmd_if.sink            i_cmd,
    qpht_res_if.source          o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int DEPTH  = qpht_pkg::DEPTH;
    localparam int NW     = qpht_pkg::NW;
    localparam int IW     = qpht_pkg::IW;
    localparam int KW     = qpht_pkg::KEY_W;
    localparam int SW     = qpht_pkg::SLOT_W;

    // ------------------------------------------------------------------
    // Configuration port. The only register, table_size, sits at byte
    // address 0; a write with paddr[2] set falls outside the map and is
    // dropped. pready is tied high, so every access completes at once.
    // ------------------------------------------------------------------
    logic [qpht_pkg::TS_W-1:0] r_table_size;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(r_table_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= qpht_pkg::TS_RESET;
        end else if (cfg_wr) begin
            r_table_size <= pwdata[qpht_pkg::TS_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Command state. The effective table size is latched when a command
    // is transferred and stays fixed while that command runs.
    // ------------------------------------------------------------------
    qpht_pkg::t_state           r_state, n_state;
    logic [qpht_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [KW-1:0]              r_key, n_key;
    logic [NW-1:0]              r_n, n_n;
    logic [NW-1:0]              r_idx, n_idx;     // slot whose data the memory now shows
    logic [NW-1:0]              r_step, n_step;   // (2i+1) mod n for the next probe
    logic [NW-1:0]              r_cnt, n_cnt;     // probes already finished
    logic                       r_hit, n_hit;
    logic [SW-1:0]              r_slot, n_slot;

    // Output register: decouples the finished result from the next command.
    logic                       r_ovalid, n_ovalid;
    logic                       r_ohit, n_ohit;
    logic [SW-1:0]              r_oslot, n_oslot;

    // Slot memory: status and key of each slot in one word. A slot whose
    // valid flop is clear has never been written and reads as empty.
    qpht_pkg::t_entry           mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    qpht_pkg::t_entry           r_rd_data;
    logic                       r_rd_vld;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    qpht_pkg::t_entry           wr_data;

    // Modulo unit.
    logic                       accept;
    logic                       mod_start;
    qpht_pkg::t_mod_res         mod_res;

    // Probe datapath.
    logic [qpht_pkg::ST_W-1:0]  cur_st;
    logic                       key_match;
    logic                       last_probe;
    logic [NW:0]                idx_sum;
    logic [NW-1:0]              idx_next;
    logic [NW:0]                step_a;
    logic [NW:0]                step_b;
    logic [NW-1:0]              step_next;

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign mod_start = accept && (i_cmd.command != qpht_pkg::CMD_NOP);

    qpht_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_cmd.key),
        .i_n     (r_n),
        .o_res   (mod_res)
    );

    // Incremental quadratic probe: slot(i+1) = slot(i) + (2i+1), and the
    // odd step itself grows by two, both kept below n with at most two
    // conditional subtractions (two are needed only when n is 1).
    always_comb begin
        cur_st     = r_rd_vld ? r_rd_data.status : qpht_pkg::ST_EMPTY;
        key_match  = (cur_st == qpht_pkg::ST_USED) && (r_rd_data.key == r_key);
        last_probe = ({1'b0, r_cnt} + (NW+1)'(1)) == {1'b0, r_n};
        idx_sum    = {1'b0, r_idx} + {1'b0, r_step};
        idx_next   = (idx_sum >= {1'b0, r_n}) ? NW'(idx_sum - {1'b0, r_n}) : NW'(idx_sum);
        step_a     = {1'b0, r_step} + (NW+1)'(2);
        step_a     = (step_a >= {1'b0, r_n}) ? (step_a - {1'b0, r_n}) : step_a;
        step_b     = (step_a >= {1'b0, r_n}) ? (step_a - {1'b0, r_n}) : step_a;
        step_next  = step_b[NW-1:0];
    end

    // Next state and datapath control.
    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_n      = r_n;
        n_idx    = r_idx;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_hit    = r_hit;
        n_slot   = r_slot;
        n_ovalid = r_ovalid;
        n_ohit   = r_ohit;
        n_oslot  = r_oslot;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = IW'(r_idx);
        wr_data  = '{status: qpht_pkg::ST_USED, key: r_key};

        i_cmd.ready = (r_state == qpht_pkg::S_IDLE);

        if (o_res.valid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            qpht_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd  = i_cmd.command;
                    n_key  = i_cmd.key;
                    n_n    = qpht_pkg::eff_size(r_table_size);
                    n_hit  = 1'b0;
                    n_slot = '0;
                    if (i_cmd.command == qpht_pkg::CMD_NOP) begin
                        n_state = qpht_pkg::S_FIN;
                    end else begin
                        n_state = qpht_pkg::S_DIV;
                    end
                end
            end
            qpht_pkg::S_DIV: begin
                if (mod_res.done) begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(mod_res.rem);
                    n_idx   = mod_res.rem;
                    n_step  = (r_n == NW'(1)) ? '0 : NW'(1);
                    n_cnt   = '0;
                    n_state = qpht_pkg::S_PROBE;
                end
            end
            qpht_pkg::S_PROBE: begin
                if (r_cmd == qpht_pkg::CMD_INSERT &&
                    (cur_st == qpht_pkg::ST_EMPTY || cur_st == qpht_pkg::ST_GONE)) begin
                    wr_en   = 1'b1;
                    n_hit   = 1'b1;
                    n_slot  = SW'(r_idx);
                    n_state = qpht_pkg::S_FIN;
                end else if (r_cmd != qpht_pkg::CMD_INSERT &&
                             cur_st == qpht_pkg::ST_EMPTY) begin
                    n_state = qpht_pkg::S_FIN;
                end else if (r_cmd != qpht_pkg::CMD_INSERT && key_match) begin
                    if (r_cmd == qpht_pkg::CMD_DELETE) begin
                        wr_en          = 1'b1;
                        wr_data.status = qpht_pkg::ST_GONE;
                    end
                    n_hit   = 1'b1;
                    n_slot  = SW'(r_idx);
                    n_state = qpht_pkg::S_FIN;
                end else if (last_probe) begin
                    n_state = qpht_pkg::S_FIN;
                end else begin
                    // The next slot does not depend on this one's data, so its
                    // read is issued while the current slot is checked.
                    rd_en   = 1'b1;
                    rd_addr = IW'(idx_next);
                    n_idx   = idx_next;
                    n_step  = step_next;
                    n_cnt   = r_cnt + NW'(1);
                end
            end
            qpht_pkg::S_FIN: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_ohit   = r_hit;
                    n_oslot  = r_slot;
                    n_state  = qpht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qpht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qpht_pkg::S_IDLE;
        end else begin
            r_state  <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_step  <= n_step;
        r_cnt   <= n_cnt;
        r_hit   <= n_hit;
        r_slot  <= n_slot;
        r_ohit  <= n_ohit;
        r_oslot <= n_oslot;
    end

    // Slot memory with a registered read port. Writes only end a command,
    // and the next read comes only in a later command, so a
    // read never races a write to the same slot.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_valid[rd_addr];
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.hit        = r_ohit;
    assign o_res.slot_index = r_oslot;

`ifndef SYNTHESIS
    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |-> (o_res.slot_index == '0))
        else $error("miss result carries a nonzero slot index");

    a_probe_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qpht_pkg::S_PROBE) |->
            (r_cnt < r_n && r_idx < r_n && r_step < r_n))
        else $error("probe counter, slot or step outside the table size");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != qpht_pkg::S_IDLE))
        else $error("transferred command did not start");

    a_mod_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_res.done |-> (r_state == qpht_pkg::S_DIV))
        else $error("modulo result arrived outside the reduction phase");

    a_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == qpht_pkg::S_PROBE && r_cmd != qpht_pkg::CMD_SEARCH))
        else $error("slot memory written outside an insert or delete probe");
`endif

endmodule

// ===== src/qpht_mod.sv =====
// Bit-serial restoring reduction of a key modulo the table size.
module qpht_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [qpht_pkg::KEY_W-1:0] i_key,
    input  logic [qpht_pkg::NW-1:0]    i_n,
    output qpht_pkg::t_mod_res         o_res
);

    localparam int NW  = qpht_pkg::NW;
    localparam int KW  = qpht_pkg::KEY_W;
    localparam int CW  = $clog2(KW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_rem;
    logic [KW-1:0] r_key;
    logic [NW:0]   trial;
    logic [NW:0]   reduced;

    // One quotient bit a cycle: shift in the next key bit, subtract if it fits.
    always_comb begin
        trial   = {r_rem, r_key[KW-1]};
        reduced = (trial >= {1'b0, i_n}) ? (trial - {1'b0, i_n}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(KW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_key <= i_key;
        end else if (r_busy) begin
            r_rem <= reduced[NW-1:0];
            r_key <= {r_key[KW-2:0], 1'b0};
        end
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;

endmodule
